>>> hw/rtl/sorted_priority_insert_queue_macros.svh
// Assertion macros for the sorted priority insert queue.
// Included by the single RTL file with concurrent assertions; no dependencies.
`ifndef SORTED_PRIORITY_INSERT_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_INSERT_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPIQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spiq assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SPIQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spiq assertion failed");

`endif

>>> hw/rtl/spiq_pkg.sv
// Shared types and constants for the sorted priority insert queue.
// No dependencies; imported by every module of the block.
package spiq_pkg;

   localparam int DEPTH_DEFAULT      = 64;
   localparam int KEY_WIDTH_DEFAULT  = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int SEQ_WIDTH   = 32;
   localparam int ITER_WIDTH  = 7;
   localparam int TOTAL_WIDTH = 40;
   localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

   // Control handed from one cell to the next along the chain.
   typedef struct packed {
      logic keep;   // cell holds its entry, it sorts before the new one
      logic valid;  // cell holds an entry
   } link_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ENCODE,
      ST_TOTAL
   } state_type;

endpackage

>>> hw/rtl/spiq_cell.sv
// One storage cell of the sorted chain: key, payload and occupied flag.
// Depends on spiq_pkg for the link_type that passes between neighbors.
module spiq_cell import spiq_pkg::*; #(
   parameter int KEY_WIDTH  = KEY_WIDTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
   parameter bit IS_HEAD    = 1'b0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         insert_en,
   input  logic signed [KEY_WIDTH-1:0]  new_key,
   input  logic signed [DATA_WIDTH-1:0] new_data,
   input  link_type                     left_link,
   input  logic signed [KEY_WIDTH-1:0]  left_key,
   input  logic signed [DATA_WIDTH-1:0] left_data,
   input  logic                         right_lt,
   output link_type                     link_out,
   output logic signed [KEY_WIDTH-1:0]  key_out,
   output logic signed [DATA_WIDTH-1:0] data_out,
   output logic                         lt_out,
   output logic                         edge_out
);

   logic                         valid_ff, valid_in;
   logic signed [KEY_WIDTH-1:0]  key_ff, key_in;
   logic signed [DATA_WIDTH-1:0] data_ff, data_in;
   logic                         lt;
   logic                         keep;

   always_comb begin
      lt   = valid_ff && (key_ff < new_key);
      // A key equal to the head's key is placed right after the head.
      keep = valid_ff && (lt || (IS_HEAD && (key_ff == new_key)));

      valid_in = valid_ff;
      key_in   = key_ff;
      data_in  = data_ff;
      if (insert_en && !keep) begin
         valid_in = valid_ff | left_link.valid;
         if (left_link.keep) begin
            key_in  = new_key;
            data_in = new_data;
         end else begin
            key_in  = left_key;
            data_in = left_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      data_ff <= data_in;
   end

   assign link_out.keep  = keep;
   assign link_out.valid = valid_ff;
   assign key_out        = key_ff;
   assign data_out       = data_ff;
   assign lt_out         = lt;
   // The last cell below the new key marks how many keys are below it.
   assign edge_out       = lt && !right_lt;

endmodule

>>> hw/rtl/spiq_encoder.sv
// Turns the one-hot boundary of the below-key prefix into a count.
// Depends on spiq_pkg for default parameter values.
module spiq_encoder import spiq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             load,
   input  logic [DEPTH-1:0] edge_vec,
   output logic [CNT_W-1:0] count
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] acc;

   always_comb begin
      acc = '0;
      for (int i = 0; i < DEPTH; i++) begin
         acc = acc | (edge_vec[i] ? CNT_W'(i + 1) : '0);
      end
      // At least one step is counted even when nothing is below the key.
      count_in = (acc == '0) ? CNT_W'(1) : acc;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

>>> hw/rtl/sorted_priority_insert_queue.sv
// Sorted priority insert queue: keeps up to DEPTH entries ordered by key.
// Usage: drive req_valid with req_data_value and req_priority_key; the request
// is taken at a clock edge where req_valid is high and req_stall is low.
// The entry is placed in key order in the same cycle, and each request gives
// one result on the rsp_ channel: its sequence number, the count of stored
// keys below its key (at least 1), the saturating running total of counts,
// and a flag when the store was full and the entry was dropped.
// The result is built in order by the cell compare (its boundary registered),
// the registered count encoder and the total adder, which writes the output
// register. One request is in flight at a time: a new request is taken only
// after the previous result has been written to the output register.
// A finished result sits in the output register; while rsp_stall holds it,
// the next request still passes the compare and encode steps and then waits.
// Reset (synchronous, active high) empties the store and clears the sequence
// number and the total; no clearing pass is needed.
// Depends on spiq_pkg, spiq_cell, spiq_encoder and the macros header.
`include "sorted_priority_insert_queue_macros.svh"

module sorted_priority_insert_queue import spiq_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int KEY_WIDTH  = KEY_WIDTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_data_value,
   input  logic signed [KEY_WIDTH-1:0]  req_priority_key,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [SEQ_WIDTH-1:0]         rsp_insert_number,
   output logic [ITER_WIDTH-1:0]        rsp_iteration_count,
   output logic [TOTAL_WIDTH-1:0]       rsp_running_total,
   output logic                         rsp_dropped_full
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   state_type              state_ff, state_in;
   logic [SEQ_WIDTH-1:0]   seq_ff, seq_in;
   logic [TOTAL_WIDTH-1:0] total_ff, total_in;
   logic [SEQ_WIDTH-1:0]   number_ff, number_in;
   logic                   dropped_ff, dropped_in;
   logic [DEPTH-1:0]       edge_ff, edge_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SEQ_WIDTH-1:0]   rsp_number_ff, rsp_number_in;
   logic [ITER_WIDTH-1:0]  rsp_count_ff, rsp_count_in;
   logic [TOTAL_WIDTH-1:0] rsp_total_ff, rsp_total_in;
   logic                   rsp_dropped_ff, rsp_dropped_in;

   logic                   accept;
   logic                   full;
   logic                   insert_en;
   logic                   encode_load;
   logic [CNT_W-1:0]       count;
   logic [TOTAL_WIDTH:0]   total_sum;
   logic [CNT_W-1:0]       fill_count;

   link_type                     link      [DEPTH+1];
   logic signed [KEY_WIDTH-1:0]  key_chain [DEPTH+1];
   logic signed [DATA_WIDTH-1:0] data_chain[DEPTH+1];
   logic [DEPTH:0]               lt_vec;
   logic [DEPTH-1:0]             valid_vec;
   logic [DEPTH-1:0]             edge_vec;

   // The head cell always sees a kept, valid neighbor on its left.
   assign link[0].keep  = 1'b1;
   assign link[0].valid = 1'b1;
   assign key_chain[0]  = req_priority_key;
   assign data_chain[0] = req_data_value;
   assign lt_vec[DEPTH] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spiq_cell #(
         .KEY_WIDTH  (KEY_WIDTH),
         .DATA_WIDTH (DATA_WIDTH),
         .IS_HEAD    (i == 0)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .insert_en  (insert_en),
         .new_key    (req_priority_key),
         .new_data   (req_data_value),
         .left_link  (link[i]),
         .left_key   (key_chain[i]),
         .left_data  (data_chain[i]),
         .right_lt   (lt_vec[i+1]),
         .link_out   (link[i+1]),
         .key_out    (key_chain[i+1]),
         .data_out   (data_chain[i+1]),
         .lt_out     (lt_vec[i]),
         .edge_out   (edge_vec[i])
      );
      assign valid_vec[i] = link[i+1].valid;
   end

   spiq_encoder #(
      .DEPTH (DEPTH)
   ) u_encoder (
      .clock    (clock),
      .load     (encode_load),
      .edge_vec (edge_ff),
      .count    (count)
   );

   assign full       = valid_vec[DEPTH-1];
   assign accept     = req_valid && !req_stall;
   assign insert_en  = accept && !full;
   assign total_sum  = {1'b0, total_ff} + (TOTAL_WIDTH + 1)'(count);
   assign fill_count = CNT_W'($countones(valid_vec));

   always_comb begin
      state_in       = state_ff;
      seq_in         = seq_ff;
      total_in       = total_ff;
      number_in      = number_ff;
      dropped_in     = dropped_ff;
      edge_in        = edge_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_number_in  = rsp_number_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_dropped_in = rsp_dropped_ff;
      req_stall      = (state_ff != ST_IDLE);
      encode_load    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               number_in  = seq_ff;
               seq_in     = seq_ff + SEQ_WIDTH'(1);
               dropped_in = full;
               edge_in    = edge_vec;
               state_in   = ST_ENCODE;
            end
         end
         ST_ENCODE: begin
            encode_load = 1'b1;
            state_in    = ST_TOTAL;
         end
         ST_TOTAL: begin
            // Wait here while the previous result is still held.
            if (!(rsp_valid_ff && rsp_stall)) begin
               total_in       = total_sum[TOTAL_WIDTH] ? TOTAL_MAX
                                                       : total_sum[TOTAL_WIDTH-1:0];
               rsp_valid_in   = 1'b1;
               rsp_number_in  = number_ff;
               rsp_count_in   = ITER_WIDTH'(count);
               rsp_total_in   = total_in;
               rsp_dropped_in = dropped_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seq_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seq_ff       <= seq_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      number_ff      <= number_in;
      dropped_ff     <= dropped_in;
      edge_ff        <= edge_in;
      rsp_number_ff  <= rsp_number_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_insert_number   = rsp_number_ff;
   assign rsp_iteration_count = rsp_count_ff;
   assign rsp_running_total   = rsp_total_ff;
   assign rsp_dropped_full    = rsp_dropped_ff;

   // Occupied cells always form an unbroken run from the head.
   `SPIQ_ASSERT_SAME(a_valid_prefix, clock, reset, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0)
   // A stored request adds exactly one occupied cell.
   `SPIQ_ASSERT_NEXT(a_insert_grows, clock, reset, insert_en, fill_count == $past(fill_count) + 1'b1)
   // A dropped request leaves the store untouched.
   `SPIQ_ASSERT_NEXT(a_drop_keeps, clock, reset, accept && full, $stable(valid_vec))
   // Keys below the new one form a prefix, so at most one boundary is marked.
   `SPIQ_ASSERT_SAME(a_edge_onehot, clock, reset, state_ff == ST_ENCODE, $onehot0(edge_ff))
   // Every taken request moves on to the count encoder.
   `SPIQ_ASSERT_NEXT(a_accept_encode, clock, reset, accept, state_ff == ST_ENCODE)

endmodule

>>> tb/tb_sorted_priority_insert_queue.sv
// Self-checking testbench for sorted_priority_insert_queue.
// A directed table, then random requests with random gaps and random result-side stalls;
// every result is checked against an in-bench sorted-store predictor. Needs spiq_pkg.
`timescale 1ns / 100ps

module tb_sorted_priority_insert_queue;
   import spiq_pkg::*;

   localparam int QUEUE_DEPTH   = DEPTH_DEFAULT;
   localparam int KW            = KEY_WIDTH_DEFAULT;
   localparam int DW            = DATA_WIDTH_DEFAULT;
   localparam int NUM_DIRECTED  = 20;
   localparam int NUM_RANDOM    = 1330;
   localparam int PRESSURE_AT   = 300;
   localparam int PRESSURE_HOLD = 250;
   localparam int CYCLE_LIMIT   = 800000;

   typedef struct {
      logic signed [DW-1:0]   data;
      logic signed [KW-1:0]   key;
      bit                     typed;
      logic [ITER_WIDTH-1:0]  count;
      logic [TOTAL_WIDTH-1:0] total;
   } stim_row_type;

   typedef struct {
      logic [SEQ_WIDTH-1:0]   insert_number;
      logic [ITER_WIDTH-1:0]  iteration_count;
      logic [TOTAL_WIDTH-1:0] running_total;
      logic                   dropped_full;
   } insert_outcome_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic signed [DW-1:0]   req_data_value = '0;
   logic signed [KW-1:0]   req_priority_key = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [SEQ_WIDTH-1:0]   rsp_insert_number;
   logic [ITER_WIDTH-1:0]  rsp_iteration_count;
   logic [TOTAL_WIDTH-1:0] rsp_running_total;
   logic                   rsp_dropped_full;

   // Predictor copy of the block state.
   logic signed [KW-1:0]   sorted_keys [QUEUE_DEPTH];
   logic signed [DW-1:0]   sorted_payloads [QUEUE_DEPTH];
   int                     stored_count = 0;
   logic [SEQ_WIDTH-1:0]   next_insert_number = '0;
   logic [TOTAL_WIDTH-1:0] count_total = '0;

   insert_outcome_type     pending_results [$];
   int                     error_count = 0;
   int                     requests_taken = 0;
   int                     cycle_count = 0;

   // The head of the table has results that follow directly from an empty store.
   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{32'sh7FFF_FFFF,  16'sd0,       1'b1, 7'd1, 40'd1},
      '{32'sh8000_0000, -16'sd32768,   1'b1, 7'd1, 40'd2},
      '{32'sh0000_0000,  16'sd32767,   1'b1, 7'd2, 40'd4},
      '{-32'sd1,        -16'sd32768,   1'b1, 7'd1, 40'd5},
      '{32'sh5555_5555,  16'sd0,       1'b1, 7'd2, 40'd7},
      '{32'shAAAA_AAAA,  16'sh5555,    1'b0, '0, '0},
      '{32'sd1,          16'shAAAA,    1'b0, '0, '0},
      '{32'sh0F0F_0F0F, -16'sd1,       1'b0, '0, '0},
      '{32'shF0F0_F0F0,  16'sd1,       1'b0, '0, '0},
      '{32'sh0000_FFFF,  16'sd32767,   1'b0, '0, '0},
      '{32'shFFFF_0000, -16'sd32767,   1'b0, '0, '0},
      '{32'sh1234_5678, -16'sd32768,   1'b0, '0, '0},
      '{32'sh00FF_00FF,  16'sh00FF,    1'b0, '0, '0},
      '{32'shFF00_FF00,  16'shFF00,    1'b0, '0, '0},
      '{32'sh3333_3333,  16'sh3333,    1'b0, '0, '0},
      '{32'shCCCC_CCCC,  16'shCCCC,    1'b0, '0, '0},
      '{32'sh6666_6666,  16'sd0,       1'b0, '0, '0},
      '{32'sh9999_9999,  16'sh7FFE,    1'b0, '0, '0},
      '{32'sh4000_0001, -16'sd2,       1'b0, '0, '0},
      '{32'sh8000_0001,  16'sd2,       1'b0, '0, '0}
   };

   sorted_priority_insert_queue u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_value      (req_data_value),
      .req_priority_key    (req_priority_key),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_insert_number   (rsp_insert_number),
      .rsp_iteration_count (rsp_iteration_count),
      .rsp_running_total   (rsp_running_total),
      .rsp_dropped_full    (rsp_dropped_full)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Inserts one entry into the predictor store and returns the result it causes.
   function automatic insert_outcome_type insert_sorted_entry(logic signed [DW-1:0] data,
                                                              logic signed [KW-1:0] key);
      insert_outcome_type   outcome;
      int                   below;
      int                   slot;
      int                   count;
      logic [TOTAL_WIDTH:0] sum;
      below = 0;
      for (int k = 0; k < stored_count; k++) begin
         if (sorted_keys[k] < key) below++;
      end
      // A key equal to the head's goes right behind the head; other ties go in front.
      if (stored_count == 0 || sorted_keys[0] > key) slot = 0;
      else slot = (below != 0) ? below : 1;
      count = (below != 0) ? below : 1;
      outcome.dropped_full = (stored_count >= QUEUE_DEPTH);
      if (!outcome.dropped_full) begin
         for (int k = stored_count; k > slot; k--) begin
            sorted_keys[k]     = sorted_keys[k-1];
            sorted_payloads[k] = sorted_payloads[k-1];
         end
         sorted_keys[slot]     = key;
         sorted_payloads[slot] = data;
         stored_count++;
      end
      sum = {1'b0, count_total} + (TOTAL_WIDTH+1)'(count);
      count_total = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_WIDTH-1:0];
      outcome.insert_number   = next_insert_number;
      outcome.iteration_count = ITER_WIDTH'(count);
      outcome.running_total   = count_total;
      next_insert_number++;
      return outcome;
   endfunction

   // Mostly short idle stretches, now and then a long one.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // Keys favour stored keys, the head key, extremes and small values, so ties are common.
   function automatic logic signed [KW-1:0] random_key();
      logic signed [KW-1:0] key;
      int                   r;
      r = $urandom_range(0, 99);
      if (r < 35) key = KW'($urandom);
      else if (r < 55 && stored_count > 0) key = sorted_keys[$urandom_range(0, stored_count-1)];
      else if (r < 65 && stored_count > 0) key = sorted_keys[0];
      else if (r < 75) begin
         case ($urandom_range(0, 3))
            0: key = {1'b1, {(KW-1){1'b0}}};
            1: key = {1'b0, {(KW-1){1'b1}}};
            2: key = '1;
            default: key = '0;
         endcase
      end else begin
         key = KW'($urandom_range(0, 16));
         key = key - 16'sd8;
      end
      return key;
   endfunction

   // Offers one request after an optional gap and records its expected result on acceptance.
   task automatic send_row(stim_row_type row, int gap);
      insert_outcome_type outcome;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data_value   <= row.data;
      req_priority_key <= row.key;
      do @(posedge clock); while (req_stall !== 1'b0);
      outcome = insert_sorted_entry(row.data, row.key);
      if (row.typed) begin
         outcome.iteration_count = row.count;
         outcome.running_total   = row.total;
      end
      pending_results.push_back(outcome);
      requests_taken++;
   endtask

   initial begin
      stim_row_type row;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_row(directed_rows[i], idle_length());
      end
      for (int i = 0; i < NUM_RANDOM; i++) begin
         row.data  = DW'($urandom);
         row.key   = random_key();
         row.typed = 1'b0;
         row.count = '0;
         row.total = '0;
         // Every few hundred requests, a stretch of back-to-back requests.
         send_row(row, ((i / 128) % 5 == 2) ? 0 : idle_length());
      end
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_sorted_priority_insert_queue: done, clean");
      end else begin
         $display("tb_sorted_priority_insert_queue: done, errors");
      end
      $finish;
   end

   // Result side back-pressure, with one long hold so the block fills and stalls requests.
   initial begin
      int hold;
      int run;
      bit pressure_done;
      pressure_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!pressure_done && requests_taken >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            hold = PRESSURE_HOLD;
         end else begin
            hold = idle_length();
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 12);
         rsp_stall <= 1'b0;
         repeat (run) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      insert_outcome_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            $error("result with no request outstanding: insert_number %0d", rsp_insert_number);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_insert_number !== want.insert_number) begin
               $error("insert_number: expected %0d, got %0d",
                      want.insert_number, rsp_insert_number);
               error_count++;
            end
            if (rsp_iteration_count !== want.iteration_count) begin
               $error("iteration_count: expected %0d, got %0d",
                      want.iteration_count, rsp_iteration_count);
               error_count++;
            end
            if (rsp_running_total !== want.running_total) begin
               $error("running_total: expected %0d, got %0d",
                      want.running_total, rsp_running_total);
               error_count++;
            end
            if (rsp_dropped_full !== want.dropped_full) begin
               $error("dropped_full: expected %0b, got %0b",
                      want.dropped_full, rsp_dropped_full);
               error_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $error("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_results.size());
      $display("tb_sorted_priority_insert_queue: done, errors");
      $finish;
   end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/spiq_pkg.sv
hw/rtl/spiq_cell.sv
hw/rtl/spiq_encoder.sv
hw/rtl/sorted_priority_insert_queue.sv
tb/tb_sorted_priority_insert_queue.sv
